### src/fourth_order_derivative_stencil_core_assert.svh
// Assertion macros for the stencil core RTL.
// No dependencies; include with the bare file name.
`ifndef FOURTH_ORDER_DERIVATIVE_STENCIL_CORE_ASSERT_SVH
`define FOURTH_ORDER_DERIVATIVE_STENCIL_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FODS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stencil core assertion failed");

// Next-cycle implication, disabled during reset.
`define FODS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stencil core assertion failed");

`endif

### src/fods_pkg.sv
// Shared types and constants for the fourth-order derivative stencil core.
// No dependencies; imported by every module of the core.
package fods_pkg;

  // One-hot stencil selects, in result order within one queue entry.
  localparam logic [4:0] OP_L0 = 5'b00001;  // first point, one-sided
  localparam logic [4:0] OP_L1 = 5'b00010;  // second point, one-sided
  localparam logic [4:0] OP_C  = 5'b00100;  // interior, centered
  localparam logic [4:0] OP_R1 = 5'b01000;  // second to last point
  localparam logic [4:0] OP_R0 = 5'b10000;  // last point

  localparam int unsigned COEF_BITS = 7;
  localparam int unsigned TAPS      = 5;
  localparam int unsigned QDEPTH    = 4;

  localparam logic [2:0] CNT_BODY = 3'd4;   // four samples held: window full
  localparam logic [2:0] CNT_SAT  = 3'd5;

  localparam logic [23:0] INV_RESET = 24'h01_0000;

  typedef struct packed {
    logic       shrt;   // frame shorter than five samples
    logic       fin;    // entry came from the frame's last sample
    logic [4:0] mask;   // stencils still to run for this entry
  } fods_ctl_t;

  localparam int unsigned CTL_BITS = $bits(fods_ctl_t);

  // Coefficients of one stencil, tap 0 (oldest) in the low bits.
  function automatic logic [TAPS*COEF_BITS-1:0] fods_coef_row(logic [4:0] op);
    logic [TAPS*COEF_BITS-1:0] row;
    unique case (op)
      OP_L0:   row = {-7'sd3, 7'sd16, -7'sd36, 7'sd48, -7'sd25};
      OP_L1:   row = {7'sd1, -7'sd6, 7'sd18, -7'sd10, -7'sd3};
      OP_C:    row = {-7'sd1, 7'sd8, 7'sd0, -7'sd8, 7'sd1};
      OP_R1:   row = {7'sd3, 7'sd10, -7'sd18, 7'sd6, -7'sd1};
      OP_R0:   row = {7'sd25, -7'sd48, 7'sd36, -7'sd16, 7'sd3};
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage

### src/fods_front.sv
// Front end: accepts sample beats, keeps the window and frame position,
// and pushes one classified entry per result-producing beat. Uses fods_pkg.
module fods_front import fods_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic                        in_tlast,
  input  logic                        q_full,
  output logic                        push,
  output fods_ctl_t                   push_ctl,
  output logic [TAPS*SAMPLE_BITS-1:0] push_win
);

  logic [SAMPLE_BITS-1:0] win_r [4];
  logic [SAMPLE_BITS-1:0] win_nxt [4];
  logic [2:0]             cnt_r, cnt_nxt;
  logic                   acc, body, first, shrt;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && !q_full;
  assign body      = (cnt_r >= CNT_BODY);
  assign first     = (cnt_r == CNT_BODY);
  assign shrt      = in_tlast && !body;
  assign push      = acc && (in_tlast || body);
  assign push_win  = {in_sample, win_r[3], win_r[2], win_r[1], win_r[0]};

  always_comb begin
    push_ctl.shrt = shrt;
    push_ctl.fin  = in_tlast;
    if (shrt) begin
      push_ctl.mask = OP_C;
    end else begin
      push_ctl.mask = OP_C | (first ? (OP_L0 | OP_L1) : 5'b0)
                           | (in_tlast ? (OP_R1 | OP_R0) : 5'b0);
    end
  end

  // Advance the window on every beat; the count gates use of stale taps.
  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = win_r[3];
      win_nxt[3] = in_sample;
      if (in_tlast) begin
        cnt_nxt = '0;
      end else if (cnt_r != CNT_SAT) begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### src/fods_queue.sv
// Short register queue between front and back ends.
// Uses fods_pkg and the assertion macro header.
`include "fourth_order_derivative_stencil_core_assert.svh"

module fods_queue import fods_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(QDEPTH);

  logic [WIDTH-1:0] mem_r [QDEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [PW:0]      cnt_r, cnt_nxt;

  assign full      = (cnt_r == (PW+1)'(QDEPTH));
  assign empty     = (cnt_r == '0);
  assign head_data = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `FODS_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full)
  `FODS_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty)
  `FODS_ASSERT_NEXT(a_cnt_grow, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

### src/fods_back.sv
// Back end: expands each queue entry into its results, one stencil per cycle
// unless stalled, then sums, scales by 1/step and saturates. Uses fods_pkg.
module fods_back import fods_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  fods_ctl_t                   q_ctl,
  input  logic [TAPS*SAMPLE_BITS-1:0] q_win,
  output logic                        q_pop,
  input  logic [23:0]                 inv_step,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);

  localparam int SW  = SAMPLE_BITS + 7;   // stencil sum
  localparam int PW  = SW + 13;           // one partial product
  localparam int PXW = PW + 12;           // full product
  localparam int QW  = PXW - 16;          // after the scale shift
  localparam int EW  = (QW > 33) ? QW : 33;
  localparam logic signed [EW-1:0] SAT_HI = EW'(64'sd2147483647);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  logic                      en;
  logic                      taken_r;
  logic [4:0]                rem_r, rem, op, rem_after;
  logic                      issue, last0;
  logic [TAPS*COEF_BITS-1:0] row;

  logic                 v1_r, last1_r, short1_r;
  logic signed [SW-1:0] term_r [TAPS];
  logic signed [SW-1:0] term_nxt [TAPS];
  logic                 v2_r, last2_r, short2_r;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic                 v3_r, last3_r, short3_r;
  logic signed [PW-1:0] plo_r, phi_r;
  logic signed [12:0]   inv_lo, inv_hi;
  logic                 ov_r, olast_r, oshort_r;
  logic [31:0]          odata_r, odata_nxt;
  logic signed [PXW-1:0] prod;
  logic signed [QW-1:0]  q_s;
  logic signed [EW-1:0]  q_ext;

  assign en = !ov_r || out_tready;

  // Pick the lowest stencil still pending on the head entry.
  assign rem       = taken_r ? rem_r : q_ctl.mask;
  assign op        = rem & (~rem + 5'd1);
  assign rem_after = rem & ~op;
  assign issue     = !q_empty && en;
  assign q_pop     = issue && (rem_after == '0);
  assign last0     = q_ctl.fin && (rem_after == '0);
  assign row       = fods_coef_row(op);

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      term_nxt[i] = q_ctl.shrt ? '0 :
        $signed(SW'($signed(q_win[i*SAMPLE_BITS +: SAMPLE_BITS])))
        * $signed(SW'($signed(row[i*COEF_BITS +: COEF_BITS])));
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum_nxt = sum_nxt + term_r[i];
    end
  end

  assign inv_lo = $signed({1'b0, inv_step[11:0]});
  assign inv_hi = $signed({1'b0, inv_step[23:12]});

  // Floor shift by 16 is a part-select of the signed product.
  assign prod  = (PXW'(phi_r) <<< 12) + PXW'(plo_r);
  assign q_s   = prod[PXW-1:16];
  assign q_ext = EW'(q_s);

  always_comb begin
    if (q_ext > SAT_HI) begin
      odata_nxt = 32'h7FFF_FFFF;
    end else if (q_ext < SAT_LO) begin
      odata_nxt = 32'h8000_0000;
    end else begin
      odata_nxt = q_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r   <= term_nxt;
      last1_r  <= last0;
      short1_r <= q_ctl.shrt;
      sum_r    <= sum_nxt;
      last2_r  <= last1_r;
      short2_r <= short1_r;
      plo_r    <= sum_r * inv_lo;
      phi_r    <= sum_r * inv_hi;
      last3_r  <= last2_r;
      short3_r <= short2_r;
      odata_r  <= odata_nxt;
      olast_r  <= last3_r;
      oshort_r <= short3_r;
    end
    if (!rst_n) begin
      taken_r <= 1'b0;
      rem_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (issue) begin
        taken_r <= (rem_after != '0);
        rem_r   <= rem_after;
      end
      if (en) begin
        v1_r <= issue;
        v2_r <= v1_r;
        v3_r <= v2_r;
        ov_r <= v3_r;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oshort_r;

endmodule

### src/fourth_order_derivative_stencil_core.sv
// Top level of the fourth-order derivative stencil core.
// Depends on fods_pkg, fods_front, fods_queue and fods_back.
//
// Streams one frame of samples in (in_tlast on the final one) and streams
// out the fourth-order accurate first derivative at every point of the
// frame, in point order, each scaled by the programmed 1/(12h) in Q8.16,
// floor-shifted by 16 and saturated to 32 bits. The centered five-point
// stencil serves interior points; one-sided stencils serve the first two
// and last two. Nothing comes out for the first four samples of a frame;
// the fifth releases three results, each later sample one, and the last
// sample releases the final three. A frame of fewer than five samples
// yields a single zero result with out_tuser set. Rate: the input takes a
// beat every cycle while the four-entry queue between the front and back
// ends has room; the back end emits one result per cycle while out_tready
// is high. A result passes the term, sum, partial-product and output
// registers after its entry reaches the queue head. out_tready stalls the
// back end; the queue lets the input keep flowing until it fills.
// inv_twelve_step resets to 1.0 (0x010000); write it only while idle.
module fourth_order_derivative_stencil_core import fods_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample, zero fill up to the byte boundary
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                in_tlast,   // frame_end
  // out_tdata: [31:0] derivative
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,
  output logic                                out_tlast,  // last_of_frame
  output logic                                out_tuser,  // short_frame
  // cfg_tdata: [23:0] inv_twelve_step
  input  logic                                cfg_tvalid,
  output logic                                cfg_tready,
  input  logic [23:0]                         cfg_tdata
);

  localparam int WIN_BITS = TAPS * SAMPLE_BITS;
  localparam int ENT_BITS = CTL_BITS + WIN_BITS;

  logic [23:0]         inv_r;
  logic                push, pop, q_full, q_empty;
  fods_ctl_t           push_ctl, head_ctl;
  logic [WIN_BITS-1:0] push_win, head_win;
  logic [ENT_BITS-1:0] head_ent;

  // Scale register: always ready; it must be written only between frames, which is not enforced here.
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= INV_RESET;
    end else if (cfg_tvalid) begin
      inv_r <= cfg_tdata;
    end
  end

  fods_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_win  (push_win)
  );

  fods_queue #(
    .WIDTH (ENT_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_win}),
    .pop       (pop),
    .head_data (head_ent),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Split the head entry back into control and window.
  assign head_ctl = fods_ctl_t'(head_ent[ENT_BITS-1:WIN_BITS]);
  assign head_win = head_ent[WIN_BITS-1:0];

  fods_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_ctl      (head_ctl),
    .q_win      (head_win),
    .q_pop      (pop),
    .inv_step   (inv_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### dv/fourth_order_derivative_stencil_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fourth_order_derivative_stencil_core: framed sample beats in,
// scaled derivative beats out, checked against an in-bench stencil predictor.
// Depends on fods_pkg and the core RTL only.
module fourth_order_derivative_stencil_core_tb import fods_pkg::*;;

  localparam int SAMPLE_BITS  = 16;
  localparam int DATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int FULL_WINDOW  = 4;     // samples held before a frame yields results
  localparam int SETTLE       = 24;    // idle cycles after the last result of a phase
  localparam int LONG_HOLD    = 300;   // receiver hold-off to back the core up
  localparam int QUIET_LIMIT  = 2500;  // cycles with no beat anywhere before giving up
  localparam int PHASE_ITEMS  = 56;
  localparam int REPORT_CAP   = 30;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   frame_end;
  } sample_beat_t;

  typedef struct packed {
    logic [31:0] derivative;
    logic        last_of_frame;
    logic        short_frame;
  } deriv_result_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [DATA_BITS-1:0] in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;
  logic                 cfg_tvalid = 1'b0;
  logic                 cfg_tready;
  logic [23:0]          cfg_tdata  = '0;

  fourth_order_derivative_stencil_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [15:0] sample
    .in_tlast   (in_tlast),    // frame_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] derivative
    .out_tlast  (out_tlast),   // last_of_frame
    .out_tuser  (out_tuser),   // short_frame
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)    // [23:0] inv_twelve_step
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample beats waiting to be offered, and derivatives owed by the core.
  sample_beat_t  sample_beats_todo [$];
  deriv_result_t derivs_owed [$];

  // Predictor state: mirror of the core's window, count and scale register.
  logic signed [SAMPLE_BITS-1:0] window_q [FULL_WINDOW];
  int unsigned                   frame_pos = 0;
  logic [23:0]                   inv_step  = INV_RESET;

  int mismatches = 0;

  // Traffic shaping knobs, set by the sequence and read by the driver/receiver.
  bit sender_steady = 1'b0;
  int hold_req      = 0;

  function automatic logic [31:0] scale_q16(longint sum);
    longint prod;
    prod = sum * longint'(inv_step);
    prod = prod >>> 16;                      // floor, not truncate toward zero
    if (prod > 64'sd2147483647)  prod = 64'sd2147483647;
    if (prod < -64'sd2147483648) prod = -64'sd2147483648;
    return prod[31:0];
  endfunction

  // Work out the derivatives one accepted sample releases, in point order.
  task automatic predict_derivatives(logic signed [SAMPLE_BITS-1:0] smp, logic fin);
    longint        w [5];
    longint        sums [$];
    deriv_result_t r;
    for (int i = 0; i < FULL_WINDOW; i++) w[i] = window_q[i];
    w[4] = smp;
    if (fin && frame_pos < FULL_WINDOW) begin
      // Short frame: one zero result flagged on both sidebands.
      r.derivative    = '0;
      r.last_of_frame = 1'b1;
      r.short_frame   = 1'b1;
      derivs_owed.push_back(r);
    end else begin
      if (frame_pos == FULL_WINDOW) begin
        // Fifth sample: the two leading one-sided points come out first.
        sums.push_back(-25 * w[0] + 48 * w[1] - 36 * w[2] + 16 * w[3] - 3 * w[4]);
        sums.push_back(-3 * w[0] - 10 * w[1] + 18 * w[2] - 6 * w[3] + w[4]);
      end
      if (frame_pos >= FULL_WINDOW)
        sums.push_back(w[0] - 8 * w[1] + 8 * w[3] - w[4]);
      if (fin) begin
        sums.push_back(3 * w[4] + 10 * w[3] - 18 * w[2] + 6 * w[1] - w[0]);
        sums.push_back(25 * w[4] - 48 * w[3] + 36 * w[2] - 16 * w[1] + 3 * w[0]);
      end
      foreach (sums[i]) begin
        r.derivative    = scale_q16(sums[i]);
        r.last_of_frame = fin && (i == sums.size() - 1);
        r.short_frame   = 1'b0;
        derivs_owed.push_back(r);
      end
    end
    if (fin) begin
      // Frame closes: restart the window from zero.
      foreach (window_q[i]) window_q[i] = '0;
      frame_pos = 0;
    end else begin
      for (int i = 0; i < FULL_WINDOW - 1; i++) window_q[i] = window_q[i + 1];
      window_q[FULL_WINDOW - 1] = smp;
      frame_pos = (frame_pos >= FULL_WINDOW + 1) ? FULL_WINDOW + 1 : frame_pos + 1;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < REPORT_CAP)
      $display("%0t mismatch on %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offer queued beats in bursts of random length, with random
  // gaps between bursts. Hold a beat unchanged until the core takes it.
  // ---------------------------------------------------------------------------
  int burst_left = 8;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        // Predict from what actually crossed the interface.
        predict_derivatives(in_tdata[SAMPLE_BITS-1:0], in_tlast);
        void'(sample_beats_todo.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if (sender_steady)
            gap_left = 0;
          else if ($urandom_range(0, 3) == 0)
            gap_left = $urandom_range(4, 20);
          else
            gap_left = $urandom_range(0, 3);
        end
      end
      // Change the offer only when no beat is stuck waiting for ready.
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (sample_beats_todo.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= sample_beats_todo[0].sample;
          in_tlast  <= sample_beats_todo[0].frame_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: mix ready and stall runs of random length; on request,
  // hold off for a long stretch so the core's queue fills and stalls input.
  // ---------------------------------------------------------------------------
  int hold_served = 0;
  int hold_left   = 0;
  int ready_run   = 0;
  bit ready_bit   = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (ready_run == 0) begin
        ready_bit = ($urandom_range(0, 2) != 0);
        ready_run = ready_bit ? $urandom_range(1, 40) : $urandom_range(1, 10);
      end
      ready_run--;
      out_tready <= ready_bit;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: match every result beat against the oldest owed derivative.
  // ---------------------------------------------------------------------------
  deriv_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (derivs_owed.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 32'hx);
      end else begin
        want = derivs_owed.pop_front();
        if (out_tdata !== want.derivative)
          report_mismatch("derivative", out_tdata, want.derivative);
        if (out_tlast !== want.last_of_frame)
          report_mismatch("last_of_frame", 32'(out_tlast), 32'(want.last_of_frame));
        if (out_tuser !== want.short_frame)
          report_mismatch("short_frame", 32'(out_tuser), 32'(want.short_frame));
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_tvalid && cfg_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("fourth_order_derivative_stencil_core_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  task automatic queue_beat(logic [SAMPLE_BITS-1:0] smp, logic fin);
    sample_beat_t b;
    b.sample    = smp;
    b.frame_end = fin;
    sample_beats_todo.push_back(b);
  endtask

  // Block until every beat is in and every result out, then let the core settle.
  task automatic wait_drained();
    while (sample_beats_todo.size() != 0 || in_tvalid || derivs_owed.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the scale register while idle and mirror it in the predictor.
  task automatic program_scale(logic [23:0] value);
    @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= value;
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    inv_step = value;
  endtask

  // Queue whole frames of mixed shape until about target beats are pending.
  task automatic queue_random_frames(int target);
    int     queued;
    int     len;
    int     kind;
    longint base;
    longint slope;
    longint curve;
    longint v;
    queued = 0;
    while (queued < target) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, 4);     // short frame
        2:       len = $urandom_range(25, 50);   // long frame, count saturates
        default: len = $urandom_range(5, 14);
      endcase
      kind  = $urandom_range(0, 3);
      base  = longint'($signed(16'($urandom)));
      slope = longint'($urandom_range(0, 2000)) - 1000;
      curve = longint'($urandom_range(0, 40)) - 20;
      for (int k = 0; k < len; k++) begin
        case (kind)
          0:       v = longint'($signed(16'($urandom)));
          1:       v = $urandom_range(0, 1) ? 32767 : -32768;
          2:       v = longint'($urandom_range(0, 32)) - 16;
          default: begin
            // Smooth polynomial, clipped to the sample range.
            v = base + slope * k + curve * k * k;
            if (v > 32767)  v = 32767;
            if (v < -32768) v = -32768;
          end
        endcase
        queue_beat(v[SAMPLE_BITS-1:0], k == len - 1);
      end
      queued += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [23:0] scale_plan [6];

  initial begin
    foreach (window_q[i]) window_q[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset scale: every short length, then the
    // shortest full frame (five results) and a six-sample frame; the full
    // frames alternate at full scale so the stencil sums reach their extremes.
    for (int len = 1; len <= 6; len++)
      for (int k = 0; k < len; k++)
        queue_beat((len == 3) ? ((k == 1) ? 16'hFFFF : 16'h0000) :
                   (len == 4) ? (k[0] ? 16'hAAAA : 16'h5555) :
                   (((k + len) % 2) != 0) ? 16'h7FFF : 16'h8000,
                   k == len - 1);
    wait_drained();

    // Random phases, each behind a fresh scale value: extremes first.
    scale_plan[0] = 24'hFF_FFFF;
    scale_plan[1] = 24'h00_0000;   // every derivative must be zero
    scale_plan[2] = 24'h00_0001;
    scale_plan[3] = 24'($urandom);
    scale_plan[4] = 24'($urandom);
    scale_plan[5] = INV_RESET;
    for (int phase = 0; phase < 6; phase++) begin
      program_scale(scale_plan[phase]);
      sender_steady <= (phase == 0 || phase == 3);
      queue_random_frames(PHASE_ITEMS);
      // Back the core up once while the sender keeps offering.
      if (phase == 0) hold_req <= hold_req + 1;
      wait_drained();
    end

    if (mismatches == 0)
      $display("fourth_order_derivative_stencil_core_tb: clean");
    else
      $display("fourth_order_derivative_stencil_core_tb: errors");
    $finish;
  end

endmodule

### fourth_order_derivative_stencil_core.f
+incdir+src
src/fods_pkg.sv
src/fods_front.sv
src/fods_queue.sv
src/fods_back.sv
src/fourth_order_derivative_stencil_core.sv
dv/fourth_order_derivative_stencil_core_tb.sv
